/* rtl/kmrmc_pkg.sv */
// shared constants, types and helper functions for the k-mer match counter
package kmrmc_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = ADDR_W + 1;
   localparam int KMER_LEN    = 64;
   localparam int CNT_W       = 40;
   localparam int REM_W       = 48;
   localparam int POS_W       = 32;
   localparam int KEY_W       = 64;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_BASE   = 2'd1;
   localparam logic [1:0] KIND_NEWRUN = 2'd2;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_DUP  = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CHECK,
      ST_SRCH_INS,
      ST_INSERT,
      ST_SRCH_FWD,
      ST_FWD_END,
      ST_SRCH_REV,
      ST_REV_END,
      ST_LAST,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic latch;
      logic start_ins;
      logic shift;
      logic start_fwd;
      logic start_rev;
      logic search;
      logic insert;
      logic hit;
      logic miss;
      logic finish;
      logic clear_run;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       win_full;
      logic       srch_done;
      logic       found;
      logic       out_free;
   } stat_type;

   function automatic logic [1:0] base_code(input logic [7:0] ch);
      logic [1:0] c;
      case (ch)
         CHAR_C:  c = 2'd1;
         CHAR_G:  c = 2'd2;
         CHAR_T:  c = 2'd3;
         default: c = 2'd0;
      endcase
      return c;
   endfunction

   function automatic logic [2*KEY_W-1:0] rev_comp(input logic [2*KEY_W-1:0] w);
      logic [2*KEY_W-1:0] r;
      for (int k = 0; k < KMER_LEN; k++) begin
         r[2*k +: 2] = ~w[2*(KMER_LEN-1-k) +: 2];
      end
      return r;
   endfunction

endpackage

/* rtl/kmrmc_ctrl.sv */
// controller state machine sequencing inserts, base steps, new-run clears and table scans
module kmrmc_ctrl import kmrmc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (stat.kind)
               KIND_INSERT: state_in = ST_SRCH_INS;
               KIND_BASE:   state_in = ST_CHECK;
               default:     state_in = ST_OUT;
            endcase
         end
         ST_CHECK: begin
            state_in = stat.win_full ? ST_SRCH_FWD : ST_LAST;
         end
         ST_SRCH_INS: begin
            if (stat.srch_done) state_in = ST_INSERT;
         end
         ST_INSERT: state_in = ST_OUT;
         ST_SRCH_FWD: begin
            if (stat.srch_done) state_in = ST_FWD_END;
         end
         ST_FWD_END: begin
            state_in = stat.found ? ST_LAST : ST_SRCH_REV;
         end
         ST_SRCH_REV: begin
            if (stat.srch_done) state_in = ST_REV_END;
         end
         ST_REV_END: state_in = ST_LAST;
         ST_LAST:    state_in = ST_OUT;
         ST_OUT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         ST_DECODE: begin
            cmd.start_ins = (stat.kind == KIND_INSERT);
            cmd.shift     = (stat.kind == KIND_BASE);
            cmd.clear_run = (stat.kind == KIND_NEWRUN);
         end
         ST_CHECK:    cmd.start_fwd = stat.win_full;
         ST_SRCH_INS: cmd.search = 1'b1;
         ST_INSERT:   cmd.insert = 1'b1;
         ST_SRCH_FWD: cmd.search = 1'b1;
         ST_FWD_END: begin
            cmd.hit       = stat.found;
            cmd.start_rev = !stat.found;
         end
         ST_SRCH_REV: cmd.search = 1'b1;
         ST_REV_END: begin
            cmd.hit  = stat.found;
            cmd.miss = !stat.found;
         end
         ST_LAST:  cmd.finish = 1'b1;
         ST_OUT:   cmd.emit = stat.out_free;
         default:  cmd = '0;
      endcase
   end

endmodule

/* rtl/kmrmc_dp.sv */
// datapath: key table memory, read window, scan counters and result register
module kmrmc_dp import kmrmc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic               csr_valid,
   input  logic [6:0]         csr_stride,
   input  logic [1:0]         req_kind,
   input  logic [KEY_W-1:0]   req_key_low,
   input  logic [KEY_W-1:0]   req_key_high,
   input  logic [POS_W-1:0]   req_ref_index,
   input  logic [7:0]         req_base_char,
   input  logic               req_last_base,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CNT_W-1:0]   rsp_matched_count,
   output logic [CNT_W-1:0]   rsp_sequential_count,
   output logic [CNT_W-1:0]   rsp_unmatched_count,
   output logic [REM_W-1:0]   rsp_remainder_bits,
   output logic [1:0]         rsp_insert_status
);

   localparam int WORD_W = 2*KEY_W + POS_W;

   logic [WORD_W-1:0]    mem [TABLE_DEPTH];
   logic [WORD_W-1:0]    rd_ff;

   logic [1:0]           kind_ff;
   logic [2*KEY_W-1:0]   ikey_ff;
   logic [POS_W-1:0]     ipos_ff;
   logic [7:0]           char_ff;
   logic                 last_ff;

   logic [6:0]           stride_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [2*KEY_W-1:0]   win_ff;
   logic [31:0]          seen_ff;
   logic [31:0]          scan_ff;
   logic [POS_W-1:0]     prev_ff;
   logic [CNT_W-1:0]     match_ff;
   logic [CNT_W-1:0]     seq_ff;
   logic [CNT_W-1:0]     miss_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [1:0]           status_ff;

   logic [2*KEY_W-1:0]   skey_ff;
   logic [COUNT_W-1:0]   ptr_ff;
   logic                 rdv_ff;
   logic                 found_ff;
   logic [POS_W-1:0]     fpos_ff;

   logic                 rsp_valid_ff;
   logic [CNT_W-1:0]     o_match_ff, o_seq_ff, o_miss_ff;
   logic [REM_W-1:0]     o_rem_ff;
   logic [1:0]           o_stat_ff;

   logic                 hit_now;
   logic                 issue;
   logic [31:0]          diff;
   logic [6:0]           step;
   logic [REM_W:0]       rem_sum;
   logic                 seq_hit;

   assign hit_now = cmd.search && rdv_ff && (rd_ff[WORD_W-1:POS_W] == skey_ff);
   assign issue   = cmd.search && !hit_now && (ptr_ff < count_ff);
   assign diff    = seen_ff - scan_ff;
   assign step    = (stride_ff == 7'd0) ? 7'd1 :
                    (stride_ff > 7'd64) ? 7'd64 : stride_ff;
   assign rem_sum = {1'b0, rem_ff} + {{(REM_W-7){1'b0}}, diff[6:0], 1'b1};
   assign seq_hit = (match_ff != '0) &&
                    ((fpos_ff == prev_ff + 32'd64) || (fpos_ff == prev_ff - 32'd64));

   assign stat.kind      = kind_ff;
   assign stat.win_full  = (diff == 32'd64);
   assign stat.srch_done = hit_now || (!rdv_ff && !issue);
   assign stat.found     = found_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ff <= mem[ptr_ff[ADDR_W-1:0]];
      end
      if (cmd.insert && !found_ff && (count_ff < COUNT_W'(TABLE_DEPTH))) begin
         mem[count_ff[ADDR_W-1:0]] <= {ikey_ff, ipos_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= req_kind;
         ikey_ff <= {req_key_high, req_key_low};
         ipos_ff <= req_ref_index;
         char_ff <= req_base_char;
         last_ff <= req_last_base;
      end
      if (cmd.start_ins) skey_ff <= ikey_ff;
      if (cmd.start_fwd) skey_ff <= win_ff;
      if (cmd.start_rev) skey_ff <= rev_comp(win_ff);
      if (hit_now) fpos_ff <= rd_ff[POS_W-1:0];
      o_match_ff <= cmd.emit ? match_ff : o_match_ff;
      o_seq_ff   <= cmd.emit ? seq_ff : o_seq_ff;
      o_miss_ff  <= cmd.emit ? miss_ff : o_miss_ff;
      o_rem_ff   <= cmd.emit ? rem_ff : o_rem_ff;
      o_stat_ff  <= cmd.emit ? status_ff : o_stat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff    <= 7'd1;
         count_ff     <= '0;
         win_ff       <= '0;
         seen_ff      <= '0;
         scan_ff      <= '0;
         prev_ff      <= '0;
         match_ff     <= '0;
         seq_ff       <= '0;
         miss_ff      <= '0;
         rem_ff       <= '0;
         status_ff    <= STAT_OK;
         ptr_ff       <= '0;
         rdv_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) stride_ff <= csr_stride;
         if (cmd.latch) status_ff <= STAT_OK;
         if (cmd.start_ins || cmd.start_fwd || cmd.start_rev) begin
            ptr_ff   <= '0;
            rdv_ff   <= 1'b0;
            found_ff <= 1'b0;
         end else if (cmd.search) begin
            rdv_ff <= issue;
            if (issue) ptr_ff <= ptr_ff + 1'b1;
            if (hit_now) found_ff <= 1'b1;
         end
         if (cmd.insert) begin
            if (found_ff) begin
               status_ff <= STAT_DUP;
            end else if (count_ff >= COUNT_W'(TABLE_DEPTH)) begin
               status_ff <= STAT_FULL;
            end else begin
               count_ff <= count_ff + 1'b1;
            end
         end
         if (cmd.shift) begin
            win_ff  <= {base_code(char_ff), win_ff[2*KEY_W-1:2]};
            seen_ff <= seen_ff + 32'd1;
         end
         if (cmd.hit) begin
            if (seq_hit && (seq_ff != '1)) seq_ff <= seq_ff + 1'b1;
            if (match_ff != '1) match_ff <= match_ff + 1'b1;
            prev_ff <= fpos_ff;
            scan_ff <= scan_ff + 32'd64;
         end
         if (cmd.miss) begin
            if (miss_ff != '1) miss_ff <= miss_ff + 1'b1;
            scan_ff <= scan_ff + {25'd0, step};
         end
         if (cmd.finish && last_ff) begin
            if (diff != 32'd0) begin
               rem_ff <= rem_sum[REM_W] ? '1 : rem_sum[REM_W-1:0];
            end
            win_ff  <= '0;
            seen_ff <= '0;
            scan_ff <= '0;
         end
         if (cmd.clear_run) begin
            match_ff <= '0;
            seq_ff   <= '0;
            miss_ff  <= '0;
            rem_ff   <= '0;
            prev_ff  <= '0;
            win_ff   <= '0;
            seen_ff  <= '0;
            scan_ff  <= '0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched_count    = o_match_ff;
   assign rsp_sequential_count = o_seq_ff;
   assign rsp_unmatched_count  = o_miss_ff;
   assign rsp_remainder_bits   = o_rem_ff;
   assign rsp_insert_status    = o_stat_ff;

endmodule

/* rtl/kmer_reference_match_counter_top.sv */
// k-mer reference match counter: a new-run or unused-kind request goes from decode to output,
// a base without a full window passes through check and last, an insert searches then writes
// a full window adds a table lookup, walking entries one per cycle
// forward lookup first, the reverse complement lookup only after a forward miss
// one request in work at a time; the next is accepted the cycle after its response issues
// synchronous reset clears counters, window, entry count and sets stride to 1
module kmer_reference_match_counter_top import kmrmc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [6:0]       csr_stride,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_kind,
   input  logic [KEY_W-1:0] req_key_low,
   input  logic [KEY_W-1:0] req_key_high,
   input  logic [POS_W-1:0] req_ref_index,
   input  logic [7:0]       req_base_char,
   input  logic             req_last_base,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [CNT_W-1:0] rsp_matched_count,
   output logic [CNT_W-1:0] rsp_sequential_count,
   output logic [CNT_W-1:0] rsp_unmatched_count,
   output logic [REM_W-1:0] rsp_remainder_bits,
   output logic [1:0]       rsp_insert_status
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   kmrmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   kmrmc_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .csr_valid            (csr_valid),
      .csr_stride           (csr_stride),
      .req_kind             (req_kind),
      .req_key_low          (req_key_low),
      .req_key_high         (req_key_high),
      .req_ref_index        (req_ref_index),
      .req_base_char        (req_base_char),
      .req_last_base        (req_last_base),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_matched_count    (rsp_matched_count),
      .rsp_sequential_count (rsp_sequential_count),
      .rsp_unmatched_count  (rsp_unmatched_count),
      .rsp_remainder_bits   (rsp_remainder_bits),
      .rsp_insert_status    (rsp_insert_status)
   );

endmodule

/* rtl/kmrmc_checker.sv */
// port-level checks for the k-mer match counter, bound to the top level
module kmrmc_checker import kmrmc_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [CNT_W-1:0] rsp_matched_count,
   input logic [CNT_W-1:0] rsp_sequential_count,
   input logic [1:0]       rsp_insert_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_matched_count))
      else $error("response dropped or changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_insert_status == STAT_OK) || (rsp_insert_status == STAT_DUP)
                    || (rsp_insert_status == STAT_FULL))
      else $error("bad insert status");

   a_seq_le_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sequential_count <= rsp_matched_count)
      else $error("sequential count exceeds match count");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind kmer_reference_match_counter_top kmrmc_checker u_kmrmc_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_matched_count    (rsp_matched_count),
   .rsp_sequential_count (rsp_sequential_count),
   .rsp_insert_status    (rsp_insert_status)
);
